// ===== rtl/core/ntt_pkg.sv =====
// Shared types, commands and constants for the mod-998244353 NTT block.
// Twiddle and inverse-length tables are computed at elaboration.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ntt_pkg;

  localparam int unsigned LOG_MAX_LEN = 12;
  localparam int unsigned DEPTH       = 1 << LOG_MAX_LEN;
  localparam int unsigned RES_W       = 30;
  localparam int unsigned EXP_W       = 31;
  localparam int unsigned LG_W        = 4;
  localparam logic [RES_W-1:0] PRIME  = 30'd998244353;
  localparam longint unsigned RootGen = 3;

  typedef logic [LOG_MAX_LEN-1:0] addr_t;
  typedef logic [LOG_MAX_LEN:0]   cnt_w_t;
  typedef logic [RES_W-1:0]       res_t;
  typedef logic [LG_W-1:0]        lg_t;
  typedef res_t root_arr_t [LOG_MAX_LEN];
  typedef res_t ilen_arr_t [LOG_MAX_LEN+1];

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_RUN   = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    CFG_LOG_LENGTH = 2'd0,
    CFG_MODE       = 2'd1,
    CFG_EXPONENT   = 2'd2
  } cfg_index_e;

  localparam logic [1:0] MODE_FWD = 2'd0;
  localparam logic [1:0] MODE_INV = 2'd1;
  localparam logic [1:0] MODE_POW = 2'd2;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_RD_OUT,
    S_REV_CHK, S_REV_R1, S_REV_W1, S_REV_W2,
    S_BF_RX, S_BF_RY, S_BF_MUL, S_BF_WAIT, S_BF_WX, S_BF_WY, S_BF_TW,
    S_PW_RD, S_PW_LD, S_PW_CHK, S_PW_MR, S_PW_MT,
    S_SC_RD, S_SC_MUL, S_SC_WAIT
  } state_e;

  typedef enum logic [2:0] {
    WSEL_IN, WSEL_ZERO, WSEL_RDATA, WSEL_X, WSEL_SUM, WSEL_DIFF, WSEL_MUL, WSEL_R
  } wsel_e;

  typedef enum logic [1:0] {
    ASEL_RDATA, ASEL_W, ASEL_R, ASEL_T
  } asel_e;

  typedef enum logic [1:0] {
    BSEL_W, BSEL_STEP, BSEL_INVLEN, BSEL_T
  } bsel_e;

  typedef struct packed {
    logic  mem_re;
    addr_t mem_raddr;
    logic  mem_we;
    addr_t mem_waddr;
    wsel_e wsel;
    logic  mul_start;
    asel_e asel;
    bsel_e bsel;
    logic  x_ld;
    logic  w_one;
    logic  w_ld;
    logic  r_one;
    logic  r_ld;
    logic  t_ld_rdata;
    logic  t_ld_mul;
    logic  e_ld;
    logic  e_shift;
    logic  out_ld;
    lg_t   stage;
    logic  inv;
    lg_t   lg;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic e_zero;
    logic e_lsb;
  } status_t;

  function automatic res_t pow_mod_c(longint unsigned base, longint unsigned e);
    longint unsigned r;
    longint unsigned t;
    longint unsigned k;
    r = 1;
    t = base % 64'(PRIME);
    k = e;
    while (k != 0) begin
      if (k[0]) r = (r * t) % 64'(PRIME);
      t = (t * t) % 64'(PRIME);
      k = k >> 1;
    end
    return res_t'(r);
  endfunction

  function automatic root_arr_t root_table(bit inv);
    root_arr_t tbl;
    res_t      w;
    for (int s = 0; s < LOG_MAX_LEN; s++) begin
      w = pow_mod_c(RootGen, (64'(PRIME) - 1) >> (s + 1));
      if (inv) w = pow_mod_c(64'(w), 64'(PRIME) - 2);
      tbl[s] = w;
    end
    return tbl;
  endfunction

  function automatic ilen_arr_t ilen_table();
    ilen_arr_t tbl;
    for (int s = 0; s <= LOG_MAX_LEN; s++) begin
      tbl[s] = pow_mod_c(64'(1) << s, 64'(PRIME) - 2);
    end
    return tbl;
  endfunction

  localparam root_arr_t FWD_ROOT = root_table(1'b0);
  localparam root_arr_t INV_ROOT = root_table(1'b1);
  localparam ilen_arr_t INV_LEN  = ilen_table();

  function automatic addr_t rev_bits(addr_t a);
    addr_t r;
    for (int b = 0; b < LOG_MAX_LEN; b++) begin
      r[b] = a[LOG_MAX_LEN-1-b];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ntt_mod_998244353.sv =====
// A write is stored as it is accepted. A read registers the stored word, then loads the output
// register once it is free; the result holds until taken, stalling the next read. A run is
// paced by the bit-serial multiplier: 2^L*L/2 butterflies, a bit-reversal sweep, up to 62
// passes per entry for the power step, one pass per entry for inverse scaling; a clear sweeps
// the whole store. After reset the store is swept to zero while input ready stays low.
// Top level: configuration registers, controller and datapath. Depends on ntt_pkg, ntt_ctrl and ntt_datapath.
`timescale 1ns / 1ps
`default_nettype none
module ntt_mod_998244353 import ntt_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [1:0]             opcode_i,
  input  wire logic [LOG_MAX_LEN-1:0] position_i,
  input  wire logic [RES_W-1:0]       value_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [RES_W-1:0]            read_value_o,
  input  wire logic                   cfg_we_i,
  input  wire logic [1:0]             cfg_index_i,
  input  wire logic [EXP_W-1:0]       cfg_data_i
);

  lg_t              log_length_q;
  logic [1:0]       mode_q;
  logic [EXP_W-1:0] exponent_q;
  cmd_t             cmd;
  status_t          status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_length_q <= lg_t'(10);
      mode_q       <= MODE_FWD;
      exponent_q   <= EXP_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_LOG_LENGTH: log_length_q <= cfg_data_i[LG_W-1:0];
        CFG_MODE:       mode_q       <= cfg_data_i[1:0];
        CFG_EXPONENT:   exponent_q   <= cfg_data_i;
        default:        mode_q       <= mode_q;
      endcase
    end
  end

  ntt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .position_i   (position_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .log_length_i (log_length_q),
    .mode_i       (mode_q),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  ntt_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .value_i      (value_i),
    .exponent_i   (exponent_q),
    .read_value_o (read_value_o)
  );

endmodule
`default_nettype wire

// ===== rtl/core/ntt_mulmod.sv =====
// Bit-serial modular multiplier, one operand bit per cycle, MSB first.
// Depends on ntt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ntt_mulmod import ntt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire res_t a_i,
  input  wire res_t b_i,
  output logic      done_o,
  output res_t      result_o
);

  logic busy_q, busy_d;
  logic done_q, done_d;
  logic [4:0] cnt_q, cnt_d;
  res_t a_q, a_d, b_q, b_d, r_q, r_d;
  logic [RES_W:0] dbl, dbl_red, acc;

  always_comb begin
    dbl     = {r_q, 1'b0};
    dbl_red = (dbl >= {1'b0, PRIME}) ? dbl - {1'b0, PRIME} : dbl;
    acc     = dbl_red + (b_q[RES_W-1] ? {1'b0, a_q} : '0);
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    a_d     = a_q;
    b_d     = b_q;
    r_d     = r_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'(RES_W - 1);
      a_d    = a_i;
      b_d    = b_i;
      r_d    = '0;
    end else if (busy_q) begin
      r_d = res_t'((acc >= {1'b0, PRIME}) ? acc - {1'b0, PRIME} : acc);
      b_d = b_q << 1;
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    r_q <= r_d;
  end

  assign done_o   = done_q;
  assign result_o = r_q;

`ifndef NO_ASSERTIONS
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("multiply started while busy");
  a_done_canonical: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (r_q < PRIME)) else $error("multiply result not reduced");
  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && cnt_q == '0) |=> done_q) else $error("missing done");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/ntt_datapath.sv =====
// Datapath: coefficient memory, operand registers, butterfly add/sub, multiplier.
// Depends on ntt_pkg and ntt_mulmod.
`timescale 1ns / 1ps
`default_nettype none
module ntt_datapath import ntt_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmd_t             cmd_i,
  output status_t               status_o,
  input  wire logic [RES_W-1:0] value_i,
  input  wire logic [EXP_W-1:0] exponent_i,
  output logic [RES_W-1:0]      read_value_o
);

  res_t mem_q [DEPTH];
  res_t rdata_q;
  res_t x_q, x_d, w_q, w_d, r_q, r_d, t_q, t_d, out_q;
  logic [EXP_W-1:0] e_q, e_d;
  res_t wdata, val_red, sum, diff, mul_a, mul_b, mul_res, step;
  logic [RES_W:0] sum_w;
  logic mul_done;

  ntt_mulmod u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.mul_start),
    .a_i      (mul_a),
    .b_i      (mul_b),
    .done_o   (mul_done),
    .result_o (mul_res)
  );

  always_comb begin
    val_red = (value_i >= PRIME) ? value_i - PRIME : value_i;
    sum_w   = {1'b0, x_q} + {1'b0, mul_res};
    sum     = res_t'((sum_w >= {1'b0, PRIME}) ? sum_w - {1'b0, PRIME} : sum_w);
    diff    = (x_q >= mul_res) ? x_q - mul_res : res_t'(x_q + PRIME - mul_res);
    step    = cmd_i.inv ? INV_ROOT[cmd_i.stage] : FWD_ROOT[cmd_i.stage];
    case (cmd_i.wsel)
      WSEL_IN:    wdata = val_red;
      WSEL_ZERO:  wdata = '0;
      WSEL_RDATA: wdata = rdata_q;
      WSEL_X:     wdata = x_q;
      WSEL_SUM:   wdata = sum;
      WSEL_DIFF:  wdata = diff;
      WSEL_MUL:   wdata = mul_res;
      WSEL_R:     wdata = r_q;
      default:    wdata = '0;
    endcase
    case (cmd_i.asel)
      ASEL_RDATA: mul_a = rdata_q;
      ASEL_W:     mul_a = w_q;
      ASEL_R:     mul_a = r_q;
      ASEL_T:     mul_a = t_q;
      default:    mul_a = '0;
    endcase
    case (cmd_i.bsel)
      BSEL_W:      mul_b = w_q;
      BSEL_STEP:   mul_b = step;
      BSEL_INVLEN: mul_b = INV_LEN[cmd_i.lg];
      BSEL_T:      mul_b = t_q;
      default:     mul_b = '0;
    endcase
    x_d = cmd_i.x_ld ? rdata_q : x_q;
    w_d = cmd_i.w_one ? res_t'(1) : (cmd_i.w_ld ? mul_res : w_q);
    r_d = cmd_i.r_one ? res_t'(1) : (cmd_i.r_ld ? mul_res : r_q);
    t_d = cmd_i.t_ld_rdata ? rdata_q : (cmd_i.t_ld_mul ? mul_res : t_q);
    e_d = cmd_i.e_ld ? exponent_i : (cmd_i.e_shift ? e_q >> 1 : e_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem_q[cmd_i.mem_waddr] <= wdata;
    end
    if (cmd_i.mem_re) begin
      rdata_q <= mem_q[cmd_i.mem_raddr];
    end
    if (cmd_i.out_ld) begin
      out_q <= rdata_q;
    end
    x_q <= x_d;
    w_q <= w_d;
    r_q <= r_d;
    t_q <= t_d;
    e_q <= e_d;
  end

  assign status_o.mul_done = mul_done;
  assign status_o.e_zero   = (e_q == '0);
  assign status_o.e_lsb    = e_q[0];
  assign read_value_o      = out_q;

endmodule
`default_nettype wire

// ===== rtl/core/ntt_ctrl.sv =====
// Controller: sequences clear, read/write, bit reversal, butterflies, power and scaling.
// Depends on ntt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ntt_ctrl import ntt_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] opcode_i,
  input  wire addr_t      position_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire lg_t        log_length_i,
  input  wire logic [1:0] mode_i,
  input  wire status_t    status_i,
  output cmd_t            cmd_o
);

  state_e state_q, state_d;
  addr_t  cnt_q, cnt_d;
  lg_t    stage_q, stage_d, lg_q, lg_d;
  logic   inv_q, inv_d, pow_q, pow_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  opcode_e op;
  cnt_w_t len_full, one_sh, grp_sh;
  addr_t  len_mask, half, kmask, bf_x, bf_y, rev_j;
  logic   last_k, rev_last, bf_last, out_free;

  always_comb begin
    op       = opcode_e'(opcode_i);
    accept   = in_valid_i && in_ready_o;
    len_full = cnt_w_t'(1) << lg_q;
    len_mask = addr_t'(len_full - cnt_w_t'(1));
    one_sh   = cnt_w_t'(1) << stage_q;
    half     = one_sh[LOG_MAX_LEN-1:0];
    kmask    = half - addr_t'(1);
    grp_sh   = {1'b0, cnt_q >> stage_q} << (stage_q + lg_t'(1));
    bf_x     = grp_sh[LOG_MAX_LEN-1:0] | (cnt_q & kmask);
    bf_y     = bf_x | half;
    rev_j    = rev_bits(cnt_q) >> (lg_t'(LOG_MAX_LEN) - lg_q);
    last_k   = (cnt_q & kmask) == kmask;
    rev_last = cnt_q == len_mask;
    bf_last  = cnt_q == (len_mask >> 1);
    out_free = !out_valid_q || out_ready_i;
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    stage_d = stage_q;
    lg_d    = lg_q;
    inv_d   = inv_q;
    pow_d   = pow_q;
    unique case (state_q)
      S_CLR: begin
        cnt_d = cnt_q + addr_t'(1);
        if (cnt_q == '1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_WRITE: state_d = S_IDLE;
            OP_READ:  state_d = S_RD_OUT;
            OP_CLEAR: begin
              state_d = S_CLR;
              cnt_d   = '0;
            end
            OP_RUN: begin
              lg_d  = (log_length_i > lg_t'(LOG_MAX_LEN)) ? lg_t'(LOG_MAX_LEN) : log_length_i;
              cnt_d = '0;
              inv_d = (mode_i == MODE_INV);
              pow_d = (mode_i == MODE_POW);
              if (mode_i == MODE_FWD || mode_i == MODE_INV || mode_i == MODE_POW) begin
                state_d = S_REV_CHK;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_RD_OUT: if (out_free) state_d = S_IDLE;
      S_REV_CHK, S_REV_W2: begin
        if (state_q == S_REV_CHK && cnt_q < rev_j) begin
          state_d = S_REV_R1;
        end else if (rev_last) begin
          cnt_d   = '0;
          stage_d = '0;
          if (lg_q == '0) begin
            state_d = inv_q ? S_SC_RD : (pow_q ? S_PW_RD : S_IDLE);
          end else begin
            state_d = S_BF_RX;
          end
        end else begin
          cnt_d   = cnt_q + addr_t'(1);
          state_d = S_REV_CHK;
        end
      end
      S_REV_R1: state_d = S_REV_W1;
      S_REV_W1: state_d = S_REV_W2;
      S_BF_RX:  state_d = S_BF_RY;
      S_BF_RY:  state_d = S_BF_MUL;
      S_BF_MUL: state_d = S_BF_WAIT;
      S_BF_WAIT: if (status_i.mul_done) state_d = S_BF_WX;
      S_BF_WX:  state_d = S_BF_WY;
      S_BF_WY, S_BF_TW: begin
        if (state_q == S_BF_WY && !last_k) begin
          state_d = S_BF_TW;
        end else if (state_q == S_BF_WY || status_i.mul_done) begin
          if (bf_last) begin
            cnt_d = '0;
            if (stage_q == lg_q - lg_t'(1)) begin
              state_d = inv_q ? S_SC_RD : (pow_q ? S_PW_RD : S_IDLE);
            end else begin
              stage_d = stage_q + lg_t'(1);
              state_d = S_BF_RX;
            end
          end else begin
            cnt_d   = cnt_q + addr_t'(1);
            state_d = S_BF_RX;
          end
        end
      end
      S_PW_RD: state_d = S_PW_LD;
      S_PW_LD: state_d = S_PW_CHK;
      S_PW_CHK: begin
        if (status_i.e_zero) begin
          if (rev_last) begin
            cnt_d   = '0;
            inv_d   = 1'b1;
            pow_d   = 1'b0;
            state_d = S_REV_CHK;
          end else begin
            cnt_d   = cnt_q + addr_t'(1);
            state_d = S_PW_RD;
          end
        end else begin
          state_d = status_i.e_lsb ? S_PW_MR : S_PW_MT;
        end
      end
      S_PW_MR: if (status_i.mul_done) state_d = S_PW_MT;
      S_PW_MT: if (status_i.mul_done) state_d = S_PW_CHK;
      S_SC_RD:  state_d = S_SC_MUL;
      S_SC_MUL: state_d = S_SC_WAIT;
      S_SC_WAIT: begin
        if (status_i.mul_done) begin
          if (rev_last) begin
            state_d = S_IDLE;
          end else begin
            cnt_d   = cnt_q + addr_t'(1);
            state_d = S_SC_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    cmd_o.wsel  = WSEL_ZERO;
    cmd_o.asel  = ASEL_RDATA;
    cmd_o.bsel  = BSEL_W;
    cmd_o.stage = stage_q;
    cmd_o.inv   = inv_q;
    cmd_o.lg    = lg_q;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_CLR: begin
        cmd_o.mem_we    = 1'b1;
        cmd_o.mem_waddr = cnt_q;
        cmd_o.wsel      = WSEL_ZERO;
      end
      S_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.mem_waddr = position_i;
        cmd_o.mem_raddr = position_i;
        cmd_o.wsel      = WSEL_IN;
        cmd_o.mem_we    = accept && op == OP_WRITE;
        cmd_o.mem_re    = accept && op == OP_READ;
      end
      S_RD_OUT: begin
        if (out_free) begin
          cmd_o.out_ld = 1'b1;
          out_valid_d  = 1'b1;
        end
      end
      S_REV_CHK: begin
        cmd_o.w_one     = 1'b1;
        cmd_o.mem_raddr = cnt_q;
        cmd_o.mem_re    = cnt_q < rev_j;
      end
      S_REV_R1: begin
        cmd_o.x_ld      = 1'b1;
        cmd_o.mem_raddr = rev_j;
        cmd_o.mem_re    = 1'b1;
      end
      S_REV_W1: begin
        cmd_o.mem_we    = 1'b1;
        cmd_o.mem_waddr = cnt_q;
        cmd_o.wsel      = WSEL_RDATA;
      end
      S_REV_W2: begin
        cmd_o.w_one     = 1'b1;
        cmd_o.mem_we    = 1'b1;
        cmd_o.mem_waddr = rev_j;
        cmd_o.wsel      = WSEL_X;
      end
      S_BF_RX: begin
        cmd_o.mem_re    = 1'b1;
        cmd_o.mem_raddr = bf_x;
      end
      S_BF_RY: begin
        cmd_o.x_ld      = 1'b1;
        cmd_o.mem_re    = 1'b1;
        cmd_o.mem_raddr = bf_y;
      end
      S_BF_MUL: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.asel      = ASEL_RDATA;
        cmd_o.bsel      = BSEL_W;
      end
      S_BF_WAIT: cmd_o.mul_start = 1'b0;
      S_BF_WX: begin
        cmd_o.mem_we    = 1'b1;
        cmd_o.mem_waddr = bf_x;
        cmd_o.wsel      = WSEL_SUM;
      end
      S_BF_WY: begin
        cmd_o.mem_we    = 1'b1;
        cmd_o.mem_waddr = bf_y;
        cmd_o.wsel      = WSEL_DIFF;
        cmd_o.w_one     = last_k;
        cmd_o.mul_start = !last_k;
        cmd_o.asel      = ASEL_W;
        cmd_o.bsel      = BSEL_STEP;
      end
      S_BF_TW: cmd_o.w_ld = status_i.mul_done;
      S_PW_RD: begin
        cmd_o.mem_re    = 1'b1;
        cmd_o.mem_raddr = cnt_q;
      end
      S_PW_LD: begin
        cmd_o.t_ld_rdata = 1'b1;
        cmd_o.r_one      = 1'b1;
        cmd_o.e_ld       = 1'b1;
      end
      S_PW_CHK: begin
        cmd_o.mem_we    = status_i.e_zero;
        cmd_o.mem_waddr = cnt_q;
        cmd_o.wsel      = WSEL_R;
        cmd_o.mul_start = !status_i.e_zero;
        cmd_o.asel      = status_i.e_lsb ? ASEL_R : ASEL_T;
        cmd_o.bsel      = BSEL_T;
      end
      S_PW_MR: begin
        cmd_o.r_ld      = status_i.mul_done;
        cmd_o.mul_start = status_i.mul_done;
        cmd_o.asel      = ASEL_T;
        cmd_o.bsel      = BSEL_T;
      end
      S_PW_MT: begin
        cmd_o.t_ld_mul = status_i.mul_done;
        cmd_o.e_shift  = status_i.mul_done;
      end
      S_SC_RD: begin
        cmd_o.mem_re    = 1'b1;
        cmd_o.mem_raddr = cnt_q;
      end
      S_SC_MUL: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.asel      = ASEL_RDATA;
        cmd_o.bsel      = BSEL_INVLEN;
      end
      S_SC_WAIT: begin
        cmd_o.mem_we    = status_i.mul_done;
        cmd_o.mem_waddr = cnt_q;
        cmd_o.wsel      = WSEL_MUL;
      end
      default: cmd_o.mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      cnt_q       <= '0;
      stage_q     <= '0;
      lg_q        <= '0;
      inv_q       <= 1'b0;
      pow_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      stage_q     <= stage_d;
      lg_q        <= lg_d;
      inv_q       <= inv_d;
      pow_q       <= pow_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire
